[rtl/tmd_pkg.sv]
// Shared types, constants and helpers for the threshold median denoiser.
package tmd_pkg;

    localparam int MAX_WIDTH_DEF       = 1024;
    localparam int MAX_HEIGHT_DEF      = 1024;
    localparam int MAX_WINDOW_AREA_DEF = 25;

    localparam int CW          = 22;  // raster index width (2047 * 2047 < 2**22)
    localparam int COL_W       = 11;  // column / dimension width
    localparam int WIN_SIDE    = 5;
    localparam int WIN_N       = WIN_SIDE * WIN_SIDE;
    localparam int RANK_W      = 5;
    localparam int SLOTS       = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] RESET_THRESHOLD = 16'd410;
    localparam logic [2:0]  RESET_SIDE      = 3'd3;
    localparam logic [10:0] RESET_DIM       = 11'd1024;

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_WINDOW_SIDE  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_FRAME_WIDTH  = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } rsp_t;

    // effective configuration after clamping
    typedef struct packed {
        logic [15:0]      threshold;
        logic [1:0]       radius;
        logic [COL_W-1:0] height;
        logic [COL_W-1:0] width;
    } cfg_t;

    // one queued command from the front to the back
    typedef struct packed {
        logic             is_pix;
        logic [7:0]       pix;
        logic [COL_W-1:0] col;
        logic [1:0]       slot;
        logic             emit;
        logic             border;
        logic             fend;
        logic [COL_W-1:0] ocol;
        logic [1:0]       oslot;
    } cmd_t;

    // window element i is part of the (2r+1)x(2r+1) bottom-right sub-window
    function automatic logic win_inc(input int i, input logic [1:0] r);
        int base;
        base = 4 - 2 * int'(r);
        return ((i / WIN_SIDE) >= base) && ((i % WIN_SIDE) >= base);
    endfunction

    // rank of the median in the sub-window
    function automatic logic [RANK_W-1:0] median_rank(input logic [1:0] r);
        logic [RANK_W-1:0] k;
        case (r)
            2'd0:    k = 5'd0;
            2'd1:    k = 5'd4;
            default: k = 5'd12;
        endcase
        return k;
    endfunction

endpackage

[rtl/tmd_queue.sv]
// Short command queue between the front and the back.
module tmd_queue #(
    parameter int DEPTH = tmd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tmd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output tmd_pkg::cmd_t head
);
    import tmd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t            store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full     = (count_reg == NW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = store_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/tmd_front.sv]
// Front end: accepts items, tracks raster positions, classifies each item.
module tmd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  tmd_pkg::cfg_t cfg,
    input  logic          cfg_we,
    input  logic          req_valid,
    output logic          req_ready,
    input  tmd_pkg::req_t req,
    input  logic          q_full,
    output logic          push,
    output tmd_pkg::cmd_t cmd
);
    import tmd_pkg::*;

    logic [COL_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [CW-1:0]    in_tot_reg;
    logic [CW-1:0]    out_cnt_reg;
    logic [CW-1:0]    orow_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [CW-1:0]    frame_reg;
    logic [12:0]      lag_reg;
    logic             busy_reg;
    logic [4:0]       step_reg;
    logic [CW-1:0]    mul_reg;
    logic [COL_W-1:0] rem_reg;
    logic [CW-1:0]    quo_reg;

    logic             accept;
    logic             is_pix;
    logic             fix;
    logic [COL_W-1:0] row1;
    logic             restart;
    logic [COL_W-1:0] row_e;
    logic [COL_W-1:0] col_e;
    logic [CW-1:0]    tot_e;
    logic [CW-1:0]    oc_e;
    logic [CW-1:0]    orow_e;
    logic [COL_W-1:0] ocol_e;
    logic             emit_pix;
    logic             emit_fl;
    logic             emit;
    logic             interior;
    logic             col_wrap;
    logic             ocol_wrap;
    logic [COL_W:0]   rem_sh;
    logic             div_ge;
    logic [COL_W-1:0] rem_new;
    logic [CW-1:0]    quo_new;

    assign req_ready = !busy_reg && !q_full;
    assign accept    = req_valid && req_ready;
    assign is_pix    = (req.opcode == OP_PIXEL);

    always_comb begin
        // a shrunk width may leave the column past the row end
        fix     = (in_col_reg >= cfg.width);
        row1    = (fix && (in_row_reg < cfg.height)) ? in_row_reg + 11'd1 : in_row_reg;
        restart = is_pix && (row1 >= cfg.height);

        row_e  = restart ? '0 : row1;
        col_e  = (restart || fix) ? '0 : in_col_reg;
        tot_e  = restart ? '0 : in_tot_reg;
        oc_e   = restart ? '0 : out_cnt_reg;
        orow_e = restart ? '0 : orow_reg;
        ocol_e = restart ? '0 : ocol_reg;

        emit_pix = (({1'b0, oc_e} + (CW+1)'(lag_reg)) < ({1'b0, tot_e} + 1'b1))
                   && (oc_e < frame_reg);
        emit_fl  = (in_row_reg >= cfg.height) && (out_cnt_reg < frame_reg);
        emit     = is_pix ? emit_pix : emit_fl;

        interior = ({1'b0, orow_e} >= (CW+1)'(cfg.radius))
                && (({1'b0, orow_e} + (CW+1)'(cfg.radius)) < (CW+1)'(cfg.height))
                && ({1'b0, ocol_e} >= (COL_W+1)'(cfg.radius))
                && (({1'b0, ocol_e} + (COL_W+1)'(cfg.radius)) < {1'b0, cfg.width});

        col_wrap  = (({1'b0, col_e} + 1'b1) == {1'b0, cfg.width});
        ocol_wrap = (({1'b0, ocol_e} + 1'b1) == {1'b0, cfg.width});

        cmd.is_pix = is_pix;
        cmd.pix    = req.pixel_in;
        cmd.col    = col_e;
        cmd.slot   = row_e[1:0];
        cmd.emit   = emit;
        cmd.border = !is_pix || !interior;
        cmd.fend   = (({1'b0, oc_e} + 1'b1) == {1'b0, frame_reg});
        cmd.ocol   = ocol_e;
        cmd.oslot  = orow_e[1:0];

        push = accept && (is_pix || emit_fl);

        // restoring divider step for out_cnt / width
        rem_sh  = {rem_reg, quo_reg[CW-1]};
        div_ge  = (rem_sh >= {1'b0, cfg.width});
        rem_new = div_ge ? COL_W'(rem_sh - {1'b0, cfg.width}) : rem_sh[COL_W-1:0];
        quo_new = {quo_reg[CW-2:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_tot_reg  <= '0;
            out_cnt_reg <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
            frame_reg   <= '0;
            lag_reg     <= '0;
            busy_reg    <= 1'b1;
            step_reg    <= '0;
            mul_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end else if (cfg_we) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'd0) begin
                frame_reg <= CW'(cfg.height) * CW'(cfg.width);
                mul_reg   <= CW'(row1) * CW'(cfg.width);
                case (cfg.radius)
                    2'd2:    lag_reg <= 13'({cfg.width, 1'b0}) + 13'd2;
                    2'd1:    lag_reg <= 13'(cfg.width) + 13'd1;
                    default: lag_reg <= '0;
                endcase
                rem_reg <= '0;
                quo_reg <= out_cnt_reg;
            end else if (step_reg <= 5'(CW)) begin
                if (step_reg == 5'd1) begin
                    in_tot_reg <= mul_reg + (fix ? '0 : CW'(in_col_reg));
                end
                rem_reg <= rem_new;
                quo_reg <= quo_new;
            end else begin
                orow_reg <= quo_reg;
                ocol_reg <= rem_reg;
                busy_reg <= 1'b0;
            end
        end else if (accept) begin
            if (is_pix) begin
                in_tot_reg <= tot_e + 1'b1;
                if (col_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= row_e + 11'd1;
                end else begin
                    in_col_reg <= col_e + 11'd1;
                    in_row_reg <= row_e;
                end
            end
            if (emit) begin
                out_cnt_reg <= oc_e + 1'b1;
                if (ocol_wrap) begin
                    ocol_reg <= '0;
                    orow_reg <= orow_e + 1'b1;
                end else begin
                    ocol_reg <= ocol_e + 11'd1;
                    orow_reg <= orow_e;
                end
            end else begin
                out_cnt_reg <= oc_e;
                orow_reg    <= orow_e;
                ocol_reg    <= ocol_e;
            end
        end
    end

endmodule

[rtl/tmd_back.sv]
// Back end: line stores, 5x5 window, rank-based median and switching decision.
module tmd_back #(
    parameter int MAX_WIDTH = tmd_pkg::MAX_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tmd_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  tmd_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tmd_pkg::rsp_t rsp
);
    import tmd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic       emit;
        logic       border;
        logic       fend;
        logic [7:0] stored;
    } meta_t;

    logic advance;

    logic       s1_v_reg;
    cmd_t       s1_cmd_reg;
    logic [7:0] rda_reg [SLOTS];
    logic [7:0] rdb_reg [SLOTS];
    logic [7:0] win_reg [WIN_N];
    logic [7:0] newcol [WIN_SIDE];

    logic       s2_v_reg;
    meta_t      s2_meta_reg;
    logic [WIN_N-1:0] less_c [WIN_N];

    logic       s3_v_reg;
    meta_t      s3_meta_reg;
    logic [WIN_N-1:0] less3_reg [WIN_N];
    logic [WIN_N-1:0] inc3_reg;
    logic [7:0] win3_reg [WIN_N];
    logic [7:0] orig3_reg;

    logic       s4_v_reg;
    meta_t      s4_meta_reg;
    logic [RANK_W-1:0] rank4_reg [WIN_N];
    logic [WIN_N-1:0]  inc4_reg;
    logic [7:0] win4_reg [WIN_N];
    logic [7:0] orig4_reg;

    logic       s5_v_reg;
    meta_t      s5_meta_reg;
    logic [7:0] med5_reg;
    logic [7:0] orig5_reg;
    logic [7:0] med_c;

    logic       s6_v_reg;
    meta_t      s6_meta_reg;
    logic [7:0] med6_reg;
    logic [7:0] orig6_reg;
    logic [7:0] diff6_reg;
    logic [23:0] prod6_reg;

    logic       out_v_reg;
    rsp_t       out_reg;

    assign advance   = !out_v_reg || rsp_ready;
    assign q_pop     = advance && q_valid;
    assign rsp_valid = out_v_reg;
    assign rsp       = out_reg;

    // four row slots, row R lives in slot R mod 4
    // the stored pixel read sees this transaction's own write when both hit the
    // same entry (a 1x1 window, or a one-column frame with a 5x5 window)
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge clk) begin
            if (q_pop) begin
                if (q_cmd.is_pix && (q_cmd.slot == 2'(g))) begin
                    mem[AW'(q_cmd.col)] <= q_cmd.pix;
                end
                rda_reg[g] <= mem[AW'(q_cmd.col)];
                if (q_cmd.is_pix && (q_cmd.slot == 2'(g)) && (q_cmd.ocol == q_cmd.col)) begin
                    rdb_reg[g] <= q_cmd.pix;
                end else begin
                    rdb_reg[g] <= mem[AW'(q_cmd.ocol)];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < WIN_SIDE; k++) begin
            if (k == WIN_SIDE - 1) begin
                newcol[k] = s1_cmd_reg.pix;
            end else begin
                newcol[k] = rda_reg[2'(s1_cmd_reg.slot + 2'(k))];
            end
        end
    end

    // pairwise order with index tie-break; excluded elements never count
    always_comb begin
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
                less_c[i][j] = win_inc(j, cfg.radius)
                    && ((win_reg[j] < win_reg[i]) || ((win_reg[j] == win_reg[i]) && (j < i)));
            end
        end
    end

    always_comb begin
        med_c = '0;
        for (int i = 0; i < WIN_N; i++) begin
            if (inc4_reg[i] && (rank4_reg[i] == median_rank(cfg.radius))) begin
                med_c = med_c | win4_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= '0;
            end
        end else if (advance) begin
            s1_v_reg  <= q_pop;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            out_v_reg <= s6_v_reg && s6_meta_reg.emit;
            if (s1_v_reg && s1_cmd_reg.is_pix) begin
                for (int k = 0; k < WIN_SIDE; k++) begin
                    for (int j = 0; j < WIN_SIDE - 1; j++) begin
                        win_reg[k*WIN_SIDE + j] <= win_reg[k*WIN_SIDE + j + 1];
                    end
                    win_reg[k*WIN_SIDE + WIN_SIDE - 1] <= newcol[k];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            s1_cmd_reg <= q_cmd;

            s2_meta_reg.emit   <= s1_cmd_reg.emit;
            s2_meta_reg.border <= s1_cmd_reg.border;
            s2_meta_reg.fend   <= s1_cmd_reg.fend;
            s2_meta_reg.stored <= rdb_reg[s1_cmd_reg.oslot];

            s3_meta_reg <= s2_meta_reg;
            for (int i = 0; i < WIN_N; i++) begin
                less3_reg[i] <= less_c[i];
                inc3_reg[i]  <= win_inc(i, cfg.radius);
                win3_reg[i]  <= win_reg[i];
            end
            orig3_reg <= win_reg[5'((4 - int'(cfg.radius)) * (WIN_SIDE + 1))];

            s4_meta_reg <= s3_meta_reg;
            for (int i = 0; i < WIN_N; i++) begin
                rank4_reg[i] <= RANK_W'($countones(less3_reg[i]));
                win4_reg[i]  <= win3_reg[i];
            end
            inc4_reg  <= inc3_reg;
            orig4_reg <= orig3_reg;

            s5_meta_reg <= s4_meta_reg;
            med5_reg    <= med_c;
            orig5_reg   <= orig4_reg;

            s6_meta_reg <= s5_meta_reg;
            med6_reg    <= med5_reg;
            orig6_reg   <= orig5_reg;
            diff6_reg   <= (med5_reg > orig5_reg) ? med5_reg - orig5_reg
                                                  : orig5_reg - med5_reg;
            prod6_reg   <= 24'(cfg.threshold) * 24'(med5_reg);

            out_reg.frame_end <= s6_meta_reg.fend;
            if (s6_meta_reg.border) begin
                out_reg.pixel_out <= s6_meta_reg.stored;
            end else if ({4'd0, diff6_reg, 12'd0} <= prod6_reg) begin
                out_reg.pixel_out <= orig6_reg;
            end else begin
                out_reg.pixel_out <= med6_reg;
            end
        end
    end

endmodule

[rtl/threshold_median_denoise.sv]
// Top level of the switching median denoiser: config registers, front, queue, back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | req_t {opcode, pixel_in}
//  rsp     | out       | rsp_valid / rsp_ready | rsp_t {pixel_out, frame_end}
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index (2b), cfg_data (16b)
//
//  Throughput: one transaction per clock on req and rsp when rsp_ready stays high
//  and no recompute runs. Path from req to rsp: the queue register, line-store read,
//  window, compare matrix, rank count, median select, threshold multiply, output
//  register; the queue registers each command even when it is empty.
//  After reset and after every cfg write the front recomputes frame size, output lag
//  and output row/column with a serial divider: req_ready is low until it finishes.
//  A stalled rsp freezes the back; the 4-entry queue lets req keep flowing until full.
//  cfg_ready is always high.
module threshold_median_denoise #(
    parameter int MAX_WIDTH       = tmd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = tmd_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW_AREA = tmd_pkg::MAX_WINDOW_AREA_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tmd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tmd_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import tmd_pkg::*;

    // radius limit from the area limit: 2 if it holds a 5x5 window, else 1
    localparam int MAX_R = (MAX_WINDOW_AREA >= 25) ? 2 : 1;
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

    logic [15:0]      threshold_reg;
    logic [2:0]       side_reg;
    logic [COL_W-1:0] height_reg;
    logic [COL_W-1:0] width_reg;

    cfg_t       cfg;
    logic [1:0] r_raw;
    logic       cfg_we;

    logic       q_full;
    logic       q_push;
    cmd_t       q_in;
    logic       q_pop;
    logic       q_nonempty;
    cmd_t       q_head;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold_reg <= RESET_THRESHOLD;
            side_reg      <= RESET_SIDE;
            height_reg    <= RESET_DIM;
            width_reg     <= RESET_DIM;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_THRESHOLD:    threshold_reg <= cfg_data;
                REG_WINDOW_SIDE:  side_reg      <= cfg_data[2:0];
                REG_FRAME_HEIGHT: height_reg    <= cfg_data[COL_W-1:0];
                REG_FRAME_WIDTH:  width_reg     <= cfg_data[COL_W-1:0];
                default:          threshold_reg <= threshold_reg;
            endcase
        end
    end

    // clamp sizes to 1..MAX, even sides round down to the odd side below, 7 to 5
    always_comb begin
        if (side_reg inside {3'd3, 3'd4}) begin
            r_raw = 2'd1;
        end else if (side_reg inside {[3'd5:3'd7]}) begin
            r_raw = 2'd2;
        end else begin
            r_raw = 2'd0;
        end
        cfg.threshold = threshold_reg;
        cfg.radius    = (r_raw > 2'(MAX_R)) ? 2'(MAX_R) : r_raw;
        if (height_reg == '0) begin
            cfg.height = 11'd1;
        end else if ({2'b00, height_reg} > MAXH) begin
            cfg.height = COL_W'(MAX_HEIGHT);
        end else begin
            cfg.height = height_reg;
        end
        if (width_reg == '0) begin
            cfg.width = 11'd1;
        end else if ({2'b00, width_reg} > MAXW) begin
            cfg.width = COL_W'(MAX_WIDTH);
        end else begin
            cfg.width = width_reg;
        end
    end

    tmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_we    (cfg_we),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_in)
    );

    tmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    tmd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_nonempty),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[rtl/tmd_checker.sv]
// Port-level checks for the denoiser and their bind to the top level.
module tmd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input tmd_pkg::rsp_t rsp,
    input logic          cfg_valid,
    input logic          cfg_ready
);

    // a stalled result transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // a config write starts the recompute window, input is held off
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !req_ready ##1 !req_ready)
        else $error("req_ready high right after a config write");

    // input never opens in the cycle right after a config write
    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_ready) |-> !$past(cfg_valid && cfg_ready))
        else $error("req_ready rose right after a config write");

endmodule

bind threshold_median_denoise tmd_checker u_tmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
